@@ hw/rtl/subarray_sum_multiple_detector_top_defines.svh @@
// Assertion macros shared by the subarray sum multiple detector RTL.
`ifndef SUBARRAY_SUM_MULTIPLE_DETECTOR_TOP_DEFINES_SVH
`define SUBARRAY_SUM_MULTIPLE_DETECTOR_TOP_DEFINES_SVH

// Same-cycle implication, clocked on clk, disabled during reset.
`define SSMD_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, clocked on clk, disabled during reset.
`define SSMD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hw/rtl/ssmd_pkg.sv @@
// Package: shared constants and types of the subarray sum multiple detector.
`timescale 1ns / 1ps
`default_nettype none

package ssmd_pkg;

	// Modulus register
	localparam int unsigned CFG_W = 7;
	localparam logic [CFG_W-1:0] MODULUS_RESET = 7'd6;

	// Parameter defaults
	localparam int unsigned MAX_MODULUS_DEF = 64;
	localparam int unsigned MAX_LENGTH_DEF  = 1024;
	localparam int unsigned VALUE_WIDTH_DEF = 16;

	// Minimum distance between two equal prefixes
	localparam int unsigned MIN_SPAN = 2;

	// Sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_CHECK,
		ST_OUT
	} seq_state_t;

	// Remainder table commands
	typedef struct packed {
		logic rd;
		logic wr;
		logic clr;
	} tbl_cmd_t;

endpackage

`default_nettype wire

@@ hw/rtl/ssmd_mod_unit.sv @@
// Bit-serial restoring remainder unit: one dividend bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module ssmd_mod_unit #(
	parameter int unsigned SUM_W = 17,
	parameter int unsigned REM_W = 6
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [SUM_W-1:0]            dividend,
	input  wire logic [ssmd_pkg::CFG_W-1:0]  divisor,
	output logic                             done,
	output logic [REM_W-1:0]                 remainder
);

	localparam int unsigned KW  = ssmd_pkg::CFG_W;
	localparam int unsigned CNT_W = $clog2(SUM_W + 1);

	logic             busy_q;
	logic [CNT_W-1:0] cnt_q;
	logic [SUM_W-1:0] dvd_q;
	logic [KW-1:0]    rem_q;
	logic [KW:0]      trial;
	logic [KW:0]      diff;
	logic [KW-1:0]    rem_nxt;

	// One restoring step: shift in next bit, subtract divisor if it fits
	always_comb begin
		trial   = {rem_q, dvd_q[SUM_W-1]};
		diff    = trial - {1'b0, divisor};
		rem_nxt = (trial >= {1'b0, divisor}) ? diff[KW-1:0] : trial[KW-1:0];
	end

	// Control: step counter and busy flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(SUM_W);
		end else if (busy_q) begin
			if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
			end else begin
				busy_q <= 1'b0;
			end
		end
	end

	// Datapath: dividend shifter and partial remainder
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
		end else if (busy_q && (cnt_q != '0)) begin
			dvd_q <= dvd_q << 1;
			rem_q <= rem_nxt;
		end
	end

	assign done      = busy_q && (cnt_q == '0);
	assign remainder = REM_W'(rem_q);

endmodule

`default_nettype wire

@@ hw/rtl/ssmd_table.sv @@
// First-occurrence table: position memory plus per-remainder seen bits.
`timescale 1ns / 1ps
`default_nettype none

module ssmd_table #(
	parameter int unsigned DEPTH  = 64,
	parameter int unsigned ADDR_W = 6,
	parameter int unsigned DATA_W = 11
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire ssmd_pkg::tbl_cmd_t  cmd,
	input  wire logic [ADDR_W-1:0]   rd_addr,
	input  wire logic [ADDR_W-1:0]   wr_addr,
	input  wire logic [DATA_W-1:0]   wr_data,
	output logic                     rd_seen,
	output logic [DATA_W-1:0]        rd_data
);

	logic [DEPTH-1:0]  valid_q;
	logic              seen_q;
	logic [DATA_W-1:0] data_q;
	logic [DATA_W-1:0] mem [DEPTH];

	// Seen bits; remainder zero is always seen at the position before start
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= DEPTH'(1);
			seen_q  <= 1'b0;
		end else begin
			if (cmd.clr) begin
				valid_q <= DEPTH'(1);
			end else if (cmd.wr) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (cmd.rd) begin
				seen_q <= valid_q[rd_addr];
			end
		end
	end

	// Position memory; entry zero is never written and reads as zero
	always_ff @(posedge clk) begin
		if (cmd.wr) begin
			mem[wr_addr] <= wr_data;
		end
		if (cmd.rd) begin
			data_q <= (rd_addr == '0) ? '0 : mem[rd_addr];
		end
	end

	assign rd_seen = seen_q;
	assign rd_data = data_q;

endmodule

`default_nettype wire

@@ hw/rtl/subarray_sum_multiple_detector_top.sv @@
// Top level: sequencer, run state and result register of the detector.
//
// Usage: values of a sequence arrive on the input channel (value, last) with
// in_valid/in_stall; each transaction yields exactly one result transaction on
// the output channel (hit, start_index, end_index, none_found, end_of_run)
// with out_valid/out_stall. A transaction is taken when valid is high and
// stall is low. The modulus register is written through cfg_write/cfg_data;
// the user must do so only while the block is idle; the block does not enforce it.
// Timing: one item at a time. An item before the first hit goes through the
// bit-serial remainder unit, which handles one sum bit per cycle over the
// SUM_W-bit sum (the wider of VALUE_WIDTH and the remainder width, plus one),
// then the table read, the check and the output load. The next item is
// accepted in the idle state after the output load. After a hit, items up to
// and including the last one skip the divider and go to the output load.
// in_stall stays high while an item is in work.
// The result sits in an output register, so the next item is accepted while
// it waits; when out_stall holds, the sequencer waits before loading the next.
// Reset: modulus returns to 6, the remainder, position and hit flag clear and
// only remainder zero counts as seen. A last item clears the same run state.
`timescale 1ns / 1ps
`default_nettype none

module subarray_sum_multiple_detector_top #(
	parameter int unsigned MAX_MODULUS = ssmd_pkg::MAX_MODULUS_DEF,
	parameter int unsigned MAX_LENGTH  = ssmd_pkg::MAX_LENGTH_DEF,
	parameter int unsigned VALUE_WIDTH = ssmd_pkg::VALUE_WIDTH_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// configuration
	input  wire logic                          cfg_write,
	input  wire logic [ssmd_pkg::CFG_W-1:0]    cfg_data,
	// input channel
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [VALUE_WIDTH-1:0]        value,
	input  wire logic                          last,
	// output channel
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic                               hit,
	output logic [$clog2(MAX_LENGTH)-1:0]      start_index,
	output logic [$clog2(MAX_LENGTH)-1:0]      end_index,
	output logic                               none_found,
	output logic                               end_of_run
);

	`include "subarray_sum_multiple_detector_top_defines.svh"

	localparam int unsigned KW    = ssmd_pkg::CFG_W;
	localparam int unsigned RW    = $clog2(MAX_MODULUS);
	localparam int unsigned PW    = $clog2(MAX_LENGTH);
	localparam int unsigned FW    = PW + 1;
	localparam int unsigned SUM_W = ((VALUE_WIDTH > RW) ? VALUE_WIDTH : RW) + 1;

	ssmd_pkg::seq_state_t state_q, state_nxt;
	ssmd_pkg::tbl_cmd_t   tbl_cmd;

	logic [KW-1:0]    modulus_q;
	logic [KW-1:0]    eff_mod;
	logic [RW-1:0]    remainder_q;
	logic [PW-1:0]    position_q;
	logic             matched_q;
	logic             last_q;

	logic             res_hit_q;
	logic [PW-1:0]    res_start_q;
	logic [PW-1:0]    res_end_q;

	logic             out_valid_q;
	logic             hit_q;
	logic [PW-1:0]    start_q;
	logic [PW-1:0]    end_q;
	logic             none_q;
	logic             eor_q;

	logic             in_acc;
	logic             out_acc;
	logic             out_free;
	logic             div_start;
	logic             div_done;
	logic [RW-1:0]    div_rem;
	logic             tbl_seen;
	logic [FW-1:0]    tbl_data;
	logic [FW-1:0]    here;
	logic [FW:0]      limit;
	logic             qualifies;

	// Modulus register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= ssmd_pkg::MODULUS_RESET;
		end else if (cfg_write) begin
			modulus_q <= cfg_data;
		end
	end

	// Effective modulus: zero acts as one, large values saturate
	always_comb begin
		if (modulus_q == '0) begin
			eff_mod = KW'(1);
		end else if (32'(modulus_q) > 32'(MAX_MODULUS)) begin
			eff_mod = KW'(MAX_MODULUS);
		end else begin
			eff_mod = modulus_q;
		end
	end

	// Shared remainder unit; loads the new sum at the accepting edge
	ssmd_mod_unit #(
		.SUM_W (SUM_W),
		.REM_W (RW)
	) u_mod (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (SUM_W'(remainder_q) + SUM_W'(value)),
		.divisor   (eff_mod),
		.done      (div_done),
		.remainder (div_rem)
	);

	// First-occurrence table
	ssmd_table #(
		.DEPTH  (MAX_MODULUS),
		.ADDR_W (RW),
		.DATA_W (FW)
	) u_tbl (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (tbl_cmd),
		.rd_addr (div_rem),
		.wr_addr (remainder_q),
		.wr_data (here),
		.rd_seen (tbl_seen),
		.rd_data (tbl_data)
	);

	// Distance check against the first occurrence
	always_comb begin
		here      = FW'(position_q) + 1'b1;
		limit     = (FW + 1)'(tbl_data) + (FW + 1)'(ssmd_pkg::MIN_SPAN);
		qualifies = tbl_seen && ((FW + 1)'(here) >= limit);
	end

	assign in_acc   = in_valid && !in_stall;
	assign out_acc  = out_valid_q && !out_stall;
	assign out_free = !out_valid_q || !out_stall;

	// Next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ssmd_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_nxt = matched_q ? ssmd_pkg::ST_OUT : ssmd_pkg::ST_DIV;
				end
			end
			ssmd_pkg::ST_DIV: begin
				if (div_done) begin
					state_nxt = ssmd_pkg::ST_CHECK;
				end
			end
			ssmd_pkg::ST_CHECK: begin
				state_nxt = ssmd_pkg::ST_OUT;
			end
			ssmd_pkg::ST_OUT: begin
				if (out_free) begin
					state_nxt = ssmd_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nxt = ssmd_pkg::ST_IDLE;
			end
		endcase
	end

	// Sequencer outputs
	always_comb begin
		in_stall    = 1'b1;
		div_start   = 1'b0;
		tbl_cmd     = '0;
		case (state_q)
			ssmd_pkg::ST_IDLE: begin
				in_stall  = 1'b0;
				div_start = in_valid && !matched_q;
			end
			ssmd_pkg::ST_DIV: begin
				tbl_cmd.rd = div_done;
			end
			ssmd_pkg::ST_CHECK: begin
				tbl_cmd.wr = !tbl_seen;
			end
			ssmd_pkg::ST_OUT: begin
				tbl_cmd.clr = out_free && last_q;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

	// Run state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ssmd_pkg::ST_IDLE;
			remainder_q <= '0;
			position_q  <= '0;
			matched_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if ((state_q == ssmd_pkg::ST_DIV) && div_done) begin
				remainder_q <= div_rem;
			end
			if (state_q == ssmd_pkg::ST_CHECK) begin
				if (qualifies) begin
					matched_q <= 1'b1;
				end
				if (32'(position_q) < MAX_LENGTH - 1) begin
					position_q <= position_q + 1'b1;
				end
			end
			if ((state_q == ssmd_pkg::ST_OUT) && out_free) begin
				out_valid_q <= 1'b1;
				if (last_q) begin
					remainder_q <= '0;
					position_q  <= '0;
					matched_q   <= 1'b0;
				end
			end else if (out_acc) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Item capture, per-item result and output register
	always_ff @(posedge clk) begin
		if (in_acc) begin
			last_q      <= last;
			res_hit_q   <= 1'b0;
			res_start_q <= '0;
			res_end_q   <= '0;
		end
		if ((state_q == ssmd_pkg::ST_CHECK) && qualifies) begin
			res_hit_q   <= 1'b1;
			res_start_q <= tbl_data[PW-1:0];
			res_end_q   <= position_q;
		end
		if ((state_q == ssmd_pkg::ST_OUT) && out_free) begin
			hit_q   <= res_hit_q;
			start_q <= res_start_q;
			end_q   <= res_end_q;
			none_q  <= last_q && !matched_q;
			eor_q   <= last_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign hit         = hit_q;
	assign start_index = start_q;
	assign end_index   = end_q;
	assign none_found  = none_q;
	assign end_of_run  = eor_q;

	// Checks
	`SSMD_ASSERT_NOW(a_done_in_div, div_done, state_q == ssmd_pkg::ST_DIV, "divider done outside divide state")
	`SSMD_ASSERT_NEXT(a_skip_after_hit, in_acc && matched_q, state_q == ssmd_pkg::ST_OUT, "item after hit was not skipped")
	`SSMD_ASSERT_NOW(a_hit_order, out_valid_q && hit_q, end_q > start_q, "hit span shorter than two")
	`SSMD_ASSERT_NOW(a_hit_none_excl, out_valid_q, !(hit_q && none_q), "hit and none_found together")

endmodule

`default_nettype wire

@@ verif/subarray_sum_multiple_detector_checker.sv @@
// Checker for the subarray sum multiple detector: predicts each result and compares it.
`timescale 1ns / 1ps

module subarray_sum_multiple_detector_checker
	import ssmd_pkg::*;
(
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_write,
	input  logic [CFG_W-1:0]                    cfg_data,
	input  logic                                in_valid,
	input  logic                                in_stall,
	input  logic [VALUE_WIDTH_DEF-1:0]          value,
	input  logic                                last,
	input  logic                                out_valid,
	input  logic                                out_stall,
	input  logic                                hit,
	input  logic [$clog2(MAX_LENGTH_DEF)-1:0]   start_index,
	input  logic [$clog2(MAX_LENGTH_DEF)-1:0]   end_index,
	input  logic                                none_found,
	input  logic                                end_of_run,
	output int                                  error_count,
	output int                                  pending_count
);

	localparam int unsigned IW = $clog2(MAX_LENGTH_DEF);
	localparam int unsigned RW = $clog2(MAX_MODULUS_DEF);

	typedef struct packed {
		logic          hit;
		logic [IW-1:0] start_idx;
		logic [IW-1:0] end_idx;
		logic          nothing_found;
		logic          run_end;
	} detection_t;

	detection_t expected_detections[$];
	int         result_count;

	// run state of the predictor
	logic [CFG_W-1:0] modulus_q;
	logic [RW-1:0]    remainder_q;
	logic [IW-1:0]    position_q;
	logic [IW:0]      first_plus_one_q [MAX_MODULUS_DEF];
	logic             seen_q [MAX_MODULUS_DEF];
	logic             matched_q;

	function automatic void clear_run();
		foreach (seen_q[i]) begin
			seen_q[i] = 1'b0;
			first_plus_one_q[i] = '0;
		end
		seen_q[0] = 1'b1;
		remainder_q = '0;
		position_q = '0;
		matched_q = 1'b0;
	endfunction

	// one item through the prefix-remainder search; updates the run state
	function automatic detection_t predict_detection(logic [VALUE_WIDTH_DEF-1:0] v,
			logic is_last);
		detection_t  d;
		int unsigned divisor;
		int unsigned rem;
		logic [IW:0] here;
		d = '0;
		d.run_end = is_last;
		if (!matched_q) begin
			// zero acts as one, large values clamp to the table size
			if (modulus_q == 0)
				divisor = 1;
			else if (modulus_q > MAX_MODULUS_DEF)
				divisor = MAX_MODULUS_DEF;
			else
				divisor = modulus_q;
			rem = (32'(remainder_q) + 32'(v)) % divisor;
			here = {1'b0, position_q} + 1'b1;
			remainder_q = rem[RW-1:0];
			if (seen_q[rem]) begin
				if (32'(here) >= 32'(first_plus_one_q[rem]) + MIN_SPAN) begin
					d.hit = 1'b1;
					d.start_idx = first_plus_one_q[rem][IW-1:0];
					d.end_idx = position_q;
					matched_q = 1'b1;
				end
			end else begin
				first_plus_one_q[rem] = here;
				seen_q[rem] = 1'b1;
			end
			if (position_q < MAX_LENGTH_DEF - 1)
				position_q = position_q + 1'b1;
		end
		if (is_last) begin
			d.nothing_found = !matched_q;
			clear_run();
		end
		return d;
	endfunction

	task automatic report_mismatch(input string msg);
		if (error_count < 40)
			$display("MISMATCH @%0t: %s", $realtime, msg);
		error_count++;
	endtask

	// watch both channels and the register port
	always @(posedge clk or negedge arst_n) begin
		detection_t want;
		if (!arst_n) begin
			modulus_q = MODULUS_RESET;
			clear_run();
			expected_detections.delete();
			pending_count = 0;
			error_count = 0;
			result_count = 0;
		end else begin
			// result transaction first: it belongs to an older item
			if (out_valid && !out_stall) begin
				result_count++;
				if (expected_detections.size() == 0) begin
					report_mismatch($sformatf("result %0d with nothing pending", result_count));
				end else begin
					want = expected_detections.pop_front();
					if (hit !== want.hit)
						report_mismatch($sformatf("result %0d hit %0b, want %0b",
							result_count, hit, want.hit));
					if (start_index !== want.start_idx)
						report_mismatch($sformatf("result %0d start_index %0d, want %0d",
							result_count, start_index, want.start_idx));
					if (end_index !== want.end_idx)
						report_mismatch($sformatf("result %0d end_index %0d, want %0d",
							result_count, end_index, want.end_idx));
					if (none_found !== want.nothing_found)
						report_mismatch($sformatf("result %0d none_found %0b, want %0b",
							result_count, none_found, want.nothing_found));
					if (end_of_run !== want.run_end)
						report_mismatch($sformatf("result %0d end_of_run %0b, want %0b",
							result_count, end_of_run, want.run_end));
				end
			end
			if (in_valid && !in_stall)
				expected_detections.push_back(predict_detection(value, last));
			if (cfg_write)
				modulus_q = cfg_data;
			pending_count = expected_detections.size();
		end
	end

endmodule

@@ verif/subarray_sum_multiple_detector_top_tb.sv @@
// Testbench top for the subarray sum multiple detector: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module subarray_sum_multiple_detector_top_tb;
	import ssmd_pkg::*;

	localparam int unsigned VW = VALUE_WIDTH_DEF;
	localparam int unsigned IW = $clog2(MAX_LENGTH_DEF);
	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned PHASE_ITEMS = 60;
	localparam int unsigned ITEM_TARGET = 750;

	typedef enum int unsigned {
		RUN_RANDOM,
		RUN_CLIMB,
		RUN_SMALL,
		RUN_MULTIPLES
	} run_style_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cfg_write = 1'b0;
	logic [CFG_W-1:0] cfg_data = '0;
	logic             in_valid = 1'b0;
	logic             in_stall;
	logic [VW-1:0]    value = '0;
	logic             last = 1'b0;
	logic             out_valid;
	logic             out_stall = 1'b0;
	logic             hit;
	logic [IW-1:0]    start_index;
	logic [IW-1:0]    end_index;
	logic             none_found;
	logic             end_of_run;

	int          error_count;
	int          pending_count;
	int          items_sent = 0;
	int unsigned cycle_count = 0;
	int unsigned divisor = 6;
	bit          tx_idle = 1'b1;
	bit          rx_idle = 1'b1;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	subarray_sum_multiple_detector_top DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_write   (cfg_write),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.value       (value),
		.last        (last),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.hit         (hit),
		.start_index (start_index),
		.end_index   (end_index),
		.none_found  (none_found),
		.end_of_run  (end_of_run)
	);

	subarray_sum_multiple_detector_checker detection_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_write     (cfg_write),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.value         (value),
		.last          (last),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.hit           (hit),
		.start_index   (start_index),
		.end_index     (end_index),
		.none_found    (none_found),
		.end_of_run    (end_of_run),
		.error_count   (error_count),
		.pending_count (pending_count)
	);

	// offer one transaction; valid stays high into the next item when no gap is drawn
	task automatic send_item(input logic [VW-1:0] v, input logic is_last);
		int unsigned gap;
		gap = tx_idle ? $urandom_range(0, 6) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		value <= v;
		last <= is_last;
		do @(posedge clk); while (in_stall);
		items_sent++;
	endtask

	// stop offering and wait until every result is back
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		wait (pending_count == 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_modulus(input logic [CFG_W-1:0] m);
		settle();
		cfg_write <= 1'b1;
		cfg_data <= m;
		@(posedge clk);
		cfg_write <= 1'b0;
		if (m == 0)
			divisor = 1;
		else if (m > MAX_MODULUS_DEF)
			divisor = MAX_MODULUS_DEF;
		else
			divisor = m;
	endtask

	function automatic logic [VW-1:0] pick_value(input run_style_t style);
		case (style)
			// prefixes step through distinct remainders
			RUN_CLIMB: return VW'(divisor * $urandom_range(0, 65534 / divisor) + 1);
			RUN_SMALL: return VW'($urandom_range(0, 3));
			RUN_MULTIPLES: return VW'(divisor * $urandom_range(0, 65535 / divisor));
			default: return VW'($urandom_range(0, 65535));
		endcase
	endfunction

	task automatic send_run(input run_style_t style, input int unsigned len,
			input logic closed);
		for (int unsigned i = 0; i < len; i++)
			send_item(pick_value(style), closed && (i == len - 1));
	endtask

	// receiver: per-result stall draw, plus one long hold-off while the sender keeps going
	initial begin
		int unsigned wait_left;
		bit          long_hold_done;
		wait_left = 0;
		long_hold_done = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!long_hold_done && items_sent >= 150 && in_valid) begin
				out_stall <= 1'b1;
				repeat (200) @(posedge clk);
				long_hold_done = 1'b1;
			end
			if (out_valid && !out_stall)
				wait_left = rx_idle ? $urandom_range(0, 6) : 0;
			if (wait_left > 0) begin
				out_stall <= 1'b1;
				wait_left--;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		logic [CFG_W-1:0] corner_moduli [6];
		run_style_t       style;
		int unsigned      len;
		int               target;
		int               phase;
		logic             open_end;
		corner_moduli = '{7'd64, 7'd1, 7'd0, 7'd127, 7'd65, 7'd2};
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (3) @(posedge clk);

		// directed part, reset modulus of six
		send_item(16'd0, 1'b1);                 // lone item: nothing found
		send_item(16'd0, 1'b0);                 // zero prefix recurs two apart, hit on last
		send_item(16'd0, 1'b1);
		send_item(16'hFFFF, 1'b0);              // max values sum to a multiple
		send_item(16'hFFFF, 1'b0);
		send_item(16'd5, 1'b0);                 // ignored after the hit
		send_item(16'h8000, 1'b1);              // last item after a hit
		for (int i = 0; i < 5; i++)
			send_item(16'd1, i == 4);           // all remainders distinct, none found
		for (int i = 0; i < 6; i++)
			send_item(16'd1, i == 5);           // wraps back to zero: whole run qualifies
		// modulus changed in the middle of a run, then zero modulus
		send_item(16'd2, 1'b0);
		send_item(16'd3, 1'b0);
		write_modulus(7'd0);
		send_item(16'd4, 1'b1);
		write_modulus(7'd127);                  // clamps to the table size
		send_item(16'd63, 1'b0);
		send_item(16'd1, 1'b1);
		write_modulus(7'd1);
		send_item(16'd9, 1'b1);

		// random phases, each under its own modulus and idle pattern
		phase = 0;
		while (items_sent < ITEM_TARGET) begin
			write_modulus(phase < 6 ? corner_moduli[phase] : CFG_W'($urandom_range(0, 127)));
			tx_idle = ($urandom_range(0, 3) != 0);
			rx_idle = ($urandom_range(0, 3) != 0);
			target = items_sent + PHASE_ITEMS;
			while (items_sent < target) begin
				style = run_style_t'($urandom_range(0, 3));
				if (style == RUN_CLIMB)
					len = $urandom_range(1, divisor + 1);
				else if ($urandom_range(0, 9) == 0)
					len = $urandom_range(13, 70);
				else
					len = $urandom_range(1, 12);
				// sometimes leave the run open so the next modulus lands mid-run
				open_end = (items_sent + len >= target) && ($urandom_range(0, 3) == 0);
				send_run(style, len, !open_end);
			end
			phase++;
		end

		settle();
		repeat (40) @(posedge clk);
		if (error_count == 0 && pending_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

@@ subarray_sum_multiple_detector_top.f @@
+incdir+hw/rtl
hw/rtl/ssmd_pkg.sv
hw/rtl/ssmd_mod_unit.sv
hw/rtl/ssmd_table.sv
hw/rtl/subarray_sum_multiple_detector_top.sv
verif/subarray_sum_multiple_detector_checker.sv
verif/subarray_sum_multiple_detector_top_tb.sv
